// ----- hdl/decimal_to_seven_segment_formatter_defines.svh -----
// assertion macros shared by the formatter rtl
`ifndef DECIMAL_TO_SEVEN_SEGMENT_FORMATTER_DEFINES_SVH
`define DECIMAL_TO_SEVEN_SEGMENT_FORMATTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DSEGFMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DSEGFMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/dsegfmt_pkg.sv -----
package dsegfmt_pkg;

  localparam int DIGITS      = 4;
  localparam int VALUE_W     = 20;
  localparam int DOT_W       = 8;
  localparam int LEN_W       = 3;
  localparam int POS_W       = 2;
  localparam int SEG_W       = 8;
  localparam int ADDR_W      = 4;
  localparam int FONT_W      = 40;
  localparam int DIGIT_W     = 4;
  localparam int IDX_W       = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  // decimal digits needed for the widest input value
  localparam int BCD_DIGITS  = 7;
  localparam int BCD_W       = BCD_DIGITS * DIGIT_W;

  // double-dabble split over equal register stages
  localparam int DD_STAGES   = 4;
  localparam int DD_STEPS    = VALUE_W / DD_STAGES;

  localparam int APB_DATA_W  = 64;
  localparam int APB_ADDR_W  = 4;
  localparam int REG_SEL_BIT = 3;

  localparam logic REG_FONT_LOW  = 1'b0;
  localparam logic REG_FONT_HIGH = 1'b1;

  localparam logic [FONT_W-1:0] FONT_LOW_RESET  = 40'h664F5B063F;
  localparam logic [FONT_W-1:0] FONT_HIGH_RESET = 40'h6F7F077D6D;

  localparam logic [SEG_W-1:0] DOT_BIT = 8'h80;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [DOT_W-1:0]   dot_mask;
    logic               show_zeros;
    logic [LEN_W-1:0]   window_len;
    logic [POS_W-1:0]   start_pos;
  } item_t;

  typedef struct packed {
    logic [SEG_W-1:0]  segments;
    logic [ADDR_W-1:0] address;
    logic              last;
    logic              overflow;
  } digit_t;

  // payload of one conversion stage
  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] rest;
    logic [DOT_W-1:0]   dot_mask;
    logic               show_zeros;
    logic [LEN_W-1:0]   len;
    logic [POS_W-1:0]   start_pos;
  } dd_t;

  // one shift-add-3 step
  function automatic logic [BCD_W-1:0] dd_shift(input logic [BCD_W-1:0] bcd,
                                                input logic bit_in);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int j = 0; j < BCD_DIGITS; j++) begin
      if (adj[DIGIT_W*j +: DIGIT_W] >= 4'd5) begin
        adj[DIGIT_W*j +: DIGIT_W] = adj[DIGIT_W*j +: DIGIT_W] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  // the steps of one stage
  function automatic dd_t dd_run(input dd_t din);
    dd_t d;
    d = din;
    for (int s = 0; s < DD_STEPS; s++) begin
      d.bcd  = dd_shift(d.bcd, d.rest[VALUE_W-1]);
      d.rest = {d.rest[VALUE_W-2:0], 1'b0};
    end
    return d;
  endfunction

  function automatic logic [SEG_W-1:0] font_byte(input logic [DIGIT_W-1:0] d,
                                                 input logic [FONT_W-1:0] lo,
                                                 input logic [FONT_W-1:0] hi);
    logic [SEG_W-1:0] b;
    unique case (d)
      4'd0:    b = lo[0*SEG_W +: SEG_W];
      4'd1:    b = lo[1*SEG_W +: SEG_W];
      4'd2:    b = lo[2*SEG_W +: SEG_W];
      4'd3:    b = lo[3*SEG_W +: SEG_W];
      4'd4:    b = lo[4*SEG_W +: SEG_W];
      4'd5:    b = hi[0*SEG_W +: SEG_W];
      4'd6:    b = hi[1*SEG_W +: SEG_W];
      4'd7:    b = hi[2*SEG_W +: SEG_W];
      4'd8:    b = hi[3*SEG_W +: SEG_W];
      4'd9:    b = hi[4*SEG_W +: SEG_W];
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

// ----- hdl/decimal_to_seven_segment_formatter.sv -----
// an item passes the conversion stages, format register, serialiser and output register
// throughput: one item per cycle into the pipe while item_stall is low; out of it one
//   digit per cycle while digit_stall is low; the serialiser holds an item to its last digit
// items with a zero window are accepted and dropped at entry, emitting nothing
// reset (rst, synchronous, active high) empties every stage and reloads the default font
`include "decimal_to_seven_segment_formatter_defines.svh"

module decimal_to_seven_segment_formatter (
  input  logic                                clk,
  input  logic                                rst,
  // item channel
  input  logic                                item_valid,
  output logic                                item_stall,
  input  dsegfmt_pkg::item_t                  item,
  // digit channel
  output logic                                digit_valid,
  input  logic                                digit_stall,
  output dsegfmt_pkg::digit_t                 digit,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dsegfmt_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [dsegfmt_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [dsegfmt_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                pready
);

  localparam int NS = dsegfmt_pkg::DD_STAGES;
  localparam int ND = dsegfmt_pkg::DIGITS;

  // ------------------------------------------------------------------
  // font registers, byte address bit 3 selects the word
  // ------------------------------------------------------------------
  logic [dsegfmt_pkg::FONT_W-1:0] font_low;
  logic [dsegfmt_pkg::FONT_W-1:0] font_high;
  logic                           cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      font_low  <= dsegfmt_pkg::FONT_LOW_RESET;
      font_high <= dsegfmt_pkg::FONT_HIGH_RESET;
    end else if (cfg_write) begin
      unique case (paddr[dsegfmt_pkg::REG_SEL_BIT])
        dsegfmt_pkg::REG_FONT_LOW:  font_low  <= pwdata[dsegfmt_pkg::FONT_W-1:0];
        dsegfmt_pkg::REG_FONT_HIGH: font_high <= pwdata[dsegfmt_pkg::FONT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[dsegfmt_pkg::REG_SEL_BIT])
      dsegfmt_pkg::REG_FONT_HIGH:
        prdata = dsegfmt_pkg::APB_DATA_W'(font_high);
      default:
        prdata = dsegfmt_pkg::APB_DATA_W'(font_low);
    endcase
  end

  // ------------------------------------------------------------------
  // entry: saturate the window, drop empty windows
  // ------------------------------------------------------------------
  dsegfmt_pkg::dd_t entry_data;
  logic             entry_valid;

  always_comb begin
    entry_data            = '0;
    entry_data.rest       = item.value;
    entry_data.dot_mask   = item.dot_mask;
    entry_data.show_zeros = item.show_zeros;
    entry_data.start_pos  = item.start_pos;
    // window longer than the digit array shows the whole array
    if (item.window_len > dsegfmt_pkg::LEN_W'(ND)) begin
      entry_data.len = dsegfmt_pkg::LEN_W'(ND);
    end else begin
      entry_data.len = item.window_len;
    end
  end

  assign entry_valid = item_valid && (item.window_len != '0);

  // ------------------------------------------------------------------
  // binary to bcd: double dabble, an equal share of the bits per stage
  // ------------------------------------------------------------------
  dsegfmt_pkg::dd_t stg_data     [NS];
  dsegfmt_pkg::dd_t stg_in_data  [NS];
  logic [NS-1:0]    stg_valid;
  logic [NS-1:0]    stg_in_valid;
  logic [NS:0]      stg_ready;
  logic             fmt_ready;

  always_comb begin
    stg_in_valid[0] = entry_valid;
    stg_in_data[0]  = entry_data;
    for (int i = 1; i < NS; i++) begin
      stg_in_valid[i] = stg_valid[i-1];
      stg_in_data[i]  = stg_data[i-1];
    end
  end

  // a stage takes new data when empty or when it hands its own on
  always_comb begin
    stg_ready[NS] = fmt_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      stg_ready[i] = !stg_valid[i] || stg_ready[i+1];
    end
  end

  assign item_stall = !stg_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (stg_ready[i]) begin
          stg_valid[i] <= stg_in_valid[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (stg_ready[i]) begin
        stg_data[i] <= dsegfmt_pkg::dd_run(stg_in_data[i]);
      end
    end
  end

  // ------------------------------------------------------------------
  // format stage: font lookup, leading-zero blanking, dots, overflow
  // ------------------------------------------------------------------
  dsegfmt_pkg::dd_t                    fmt_src;
  logic [dsegfmt_pkg::SEG_W-1:0]       seg_next [ND];
  logic                                ovf_next;
  logic                                fmt_valid;
  logic [dsegfmt_pkg::SEG_W-1:0]       fmt_seg  [ND];
  logic [dsegfmt_pkg::LEN_W-1:0]       fmt_len;
  logic [dsegfmt_pkg::POS_W-1:0]       fmt_pos;
  logic                                fmt_ovf;
  logic                                ser_ready;

  assign fmt_src = stg_data[NS-1];

  always_comb begin
    logic                                leading;
    logic [dsegfmt_pkg::DIGIT_W-1:0]     d;
    logic [dsegfmt_pkg::SEG_W-1:0]       s;
    leading = 1'b1;
    for (int i = 0; i < ND; i++) begin
      // most significant digit first
      d = fmt_src.bcd[dsegfmt_pkg::DIGIT_W*(ND-1-i) +: dsegfmt_pkg::DIGIT_W];
      if (d != '0) begin
        leading = 1'b0;
        s = dsegfmt_pkg::font_byte(d, font_low, font_high);
      end else if (fmt_src.show_zeros || !leading || i == ND - 1) begin
        // the rightmost digit always shows
        s = dsegfmt_pkg::font_byte(d, font_low, font_high);
      end else begin
        s = '0;
      end
      // dot mask msb belongs to the leftmost digit
      if (fmt_src.dot_mask[dsegfmt_pkg::DOT_W-1-i]) begin
        s = s | dsegfmt_pkg::DOT_BIT;
      end
      seg_next[i] = s;
    end
  end

  // any decimal digit above the array means the value was too large
  assign ovf_next  = |fmt_src.bcd[dsegfmt_pkg::BCD_W-1:dsegfmt_pkg::DIGIT_W*ND];
  assign fmt_ready = !fmt_valid || ser_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt_valid <= 1'b0;
    end else if (fmt_ready) begin
      fmt_valid <= stg_valid[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (fmt_ready) begin
      fmt_seg <= seg_next;
      fmt_len <= fmt_src.len;
      fmt_pos <= fmt_src.start_pos;
      fmt_ovf <= ovf_next;
    end
  end

  // ------------------------------------------------------------------
  // serialiser: one digit of the window per cycle, unless the digit channel stalls, into the output register
  // ------------------------------------------------------------------
  logic                                ser_valid;
  logic [dsegfmt_pkg::SEG_W-1:0]       ser_seg [ND];
  logic [dsegfmt_pkg::LEN_W-1:0]       ser_len;
  logic [dsegfmt_pkg::POS_W-1:0]       ser_pos;
  logic                                ser_ovf;
  logic [dsegfmt_pkg::IDX_W-1:0]       ser_idx;
  logic                                ser_last;
  logic [dsegfmt_pkg::LEN_W-1:0]       ser_sel_full;
  logic [dsegfmt_pkg::IDX_W-1:0]       ser_sel;
  logic                                out_load;

  assign out_load  = !digit_valid || !digit_stall;
  assign ser_last  = (dsegfmt_pkg::LEN_W'(ser_idx) + dsegfmt_pkg::LEN_W'(1)) == ser_len;
  assign ser_ready = !ser_valid || (out_load && ser_last);

  // window holds the rightmost digits of the array
  assign ser_sel_full = dsegfmt_pkg::LEN_W'(ND) - ser_len + dsegfmt_pkg::LEN_W'(ser_idx);
  assign ser_sel      = ser_sel_full[dsegfmt_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_idx   <= '0;
    end else if (ser_ready) begin
      ser_valid <= fmt_valid;
      ser_idx   <= '0;
    end else if (out_load) begin
      ser_idx <= ser_idx + dsegfmt_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ser_ready) begin
      ser_seg <= fmt_seg;
      ser_len <= fmt_len;
      ser_pos <= fmt_pos;
      ser_ovf <= fmt_ovf;
    end
  end

  // output register parts the serialiser from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_valid <= 1'b0;
    end else if (out_load) begin
      digit_valid <= ser_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      digit.segments <= ser_seg[ser_sel];
      digit.address  <= dsegfmt_pkg::ADDR_W'(ser_pos) + dsegfmt_pkg::ADDR_W'(ser_idx);
      digit.last     <= ser_last;
      digit.overflow <= ser_ovf;
    end
  end

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  `DSEGFMT_ASSERT_NOW(a_ser_idx_in_window, ser_valid,
    (ser_len != '0) && (dsegfmt_pkg::LEN_W'(ser_idx) < ser_len),
    "serialiser index outside its window")

  `DSEGFMT_ASSERT_NOW(a_stall_only_when_full, item_stall, stg_valid[0],
    "item stalled with an empty first stage")

  `DSEGFMT_ASSERT_NEXT(a_run_continues, digit_valid && !digit_stall && !digit.last,
    digit_valid && (digit.overflow == $past(digit.overflow)) &&
    (digit.address == $past(digit.address) + dsegfmt_pkg::ADDR_W'(1)),
    "digit run broken before its last digit")

endmodule

// ----- verif/tb_decimal_to_seven_segment_formatter.sv -----
`timescale 1ns / 100ps

module tb_decimal_to_seven_segment_formatter;
  import dsegfmt_pkg::*;

  // settle time after the last expected digit: pipe latency plus a margin
  localparam int DRAIN_CYCLES = 16;
  // generous bound on the whole run, in ns
  localparam int TIMEOUT_NS   = 5_000_000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 45;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // item channel
  logic  item_valid = 1'b0;
  logic  item_stall;
  item_t in_item    = '0;

  // digit channel
  logic   digit_valid;
  logic   digit_stall = 1'b0;
  digit_t out_digit;

  // configuration port
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // local copy of the font registers
  logic [FONT_W-1:0] font_lo = FONT_LOW_RESET;
  logic [FONT_W-1:0] font_hi = FONT_HIGH_RESET;

  // digits still owed by the block, oldest first
  digit_t expected_digits[$];
  int     errors     = 0;
  // set for stretches with no gaps and no stalls on either side
  bit     no_idle    = 1'b0;
  int     stall_left = 0;

  always #5 clk = ~clk;

  decimal_to_seven_segment_formatter u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (in_item),
    .digit_valid (digit_valid),
    .digit_stall (digit_stall),
    .digit       (out_digit),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // gap length: mostly none, some short, a few long
  function automatic int idle_cycles();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic item_t make_item(input int unsigned value, input logic [DOT_W-1:0] dots,
                                      input logic zeros, input int unsigned len,
                                      input int unsigned pos);
    item_t it;
    it.value      = VALUE_W'(value);
    it.dot_mask   = dots;
    it.show_zeros = zeros;
    it.window_len = LEN_W'(len);
    it.start_pos  = POS_W'(pos);
    return it;
  endfunction

  // random item, weighted towards short numbers so that blanking gets exercised
  function automatic item_t rand_item();
    item_t       it;
    int unsigned r;
    r = $urandom_range(0, 4);
    case (r)
      0:       it.value = VALUE_W'($urandom_range(0, 9));
      1:       it.value = VALUE_W'($urandom_range(0, 99));
      2, 3:    it.value = VALUE_W'($urandom_range(0, 9999));
      default: it.value = VALUE_W'($urandom);
    endcase
    it.dot_mask   = DOT_W'($urandom);
    it.show_zeros = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 9);
    if (r == 0) begin
      it.window_len = '0;
    end else if (r == 1) begin
      it.window_len = LEN_W'($urandom_range(DIGITS + 1, 7));
    end else begin
      it.window_len = LEN_W'($urandom_range(1, DIGITS));
    end
    it.start_pos = POS_W'($urandom);
    return it;
  endfunction

  // expected digit run for one item under the current font
  function automatic void format_digits(input item_t it);
    logic [SEG_W-1:0] seg [DIGITS];
    int unsigned      lim, div, v, d, n;
    bit               blank_run;
    digit_t           exp_d;
    lim = 1;
    for (int i = 0; i < DIGITS; i++) lim = lim * 10;
    // too large: shown modulo 10^DIGITS, flagged on every digit
    v = it.value % lim;
    div = lim;
    blank_run = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      div = div / 10;
      d = (v / div) % 10;
      if (d != 0) blank_run = 1'b0;
      // leading zeros go dark unless asked for, the rightmost digit always shows
      if (d == 0 && blank_run && !it.show_zeros && i != DIGITS - 1) begin
        seg[i] = '0;
      end else if (d < 5) begin
        seg[i] = font_lo[SEG_W*d +: SEG_W];
      end else begin
        seg[i] = font_hi[SEG_W*(d-5) +: SEG_W];
      end
      // dot mask msb belongs to the leftmost digit; a font bit 7 is kept either way
      if (it.dot_mask[DOT_W-1-i]) seg[i] = seg[i] | DOT_BIT;
    end
    // long windows saturate, an empty window emits nothing
    n = (it.window_len > DIGITS) ? DIGITS : it.window_len;
    for (int k = 0; k < n; k++) begin
      exp_d.segments = seg[DIGITS-n+k];
      exp_d.address  = ADDR_W'(it.start_pos + k);
      exp_d.last     = (k == n - 1);
      exp_d.overflow = (it.value >= lim);
      expected_digits.push_back(exp_d);
    end
  endfunction

  function automatic void compare_digit(input digit_t got);
    digit_t exp_d;
    if (expected_digits.size() == 0) begin
      $display("%0t: unexpected digit %p", $time, got);
      errors++;
      return;
    end
    exp_d = expected_digits.pop_front();
    if (got.segments !== exp_d.segments) begin
      $display("%0t: segments expected %h got %h", $time, exp_d.segments, got.segments);
      errors++;
    end
    if (got.address !== exp_d.address) begin
      $display("%0t: address expected %0d got %0d", $time, exp_d.address, got.address);
      errors++;
    end
    if (got.last !== exp_d.last) begin
      $display("%0t: last expected %b got %b", $time, exp_d.last, got.last);
      errors++;
    end
    if (got.overflow !== exp_d.overflow) begin
      $display("%0t: overflow expected %b got %b", $time, exp_d.overflow, got.overflow);
      errors++;
    end
  endfunction

  // digit sink: check each accepted digit, then pick the next stall
  always @(posedge clk) begin
    if (digit_valid && !digit_stall && !rst) compare_digit(out_digit);
    if (stall_left > 0) begin
      stall_left--;
      digit_stall <= 1'b1;
    end else begin
      stall_left = idle_cycles();
      if (stall_left > 0) begin
        stall_left--;
        digit_stall <= 1'b1;
      end else begin
        digit_stall <= 1'b0;
      end
    end
  end

  // present one item, hold it until taken, then book its digits
  task automatic send_item(input item_t it);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item    <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    format_digits(it);
  endtask

  // let every owed digit arrive, then wait out the drain time
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write one font register, then read it back
  task automatic write_font(input logic sel, input logic [FONT_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(sel) << REG_SEL_BIT;
    pwdata  <= APB_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_FONT_LOW) font_lo = val;
    else font_hi = val;
    // read back: setup straight after the write access
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[FONT_W-1:0] !== val) begin
      $display("%0t: font register %0d read expected %h got %h", $time, sel, val,
               prdata[FONT_W-1:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_fonts(input logic [FONT_W-1:0] lo, input logic [FONT_W-1:0] hi);
    wait_idle();
    write_font(REG_FONT_LOW, lo);
    write_font(REG_FONT_HIGH, hi);
  endtask

  // reset font: extremes of every field, blanking, saturation, empty window, overflow
  task automatic test_reset_font();
    send_item(make_item(0, 8'h00, 1'b0, 4, 0));
    send_item(make_item(0, 8'h00, 1'b1, 4, 0));
    send_item(make_item(9999, 8'hFF, 1'b0, 4, 3));
    send_item(make_item(10000, 8'h00, 1'b0, 4, 0));
    send_item(make_item(1048575, 8'hA5, 1'b1, 7, 2));
    send_item(make_item(1234, 8'h0F, 1'b0, 2, 1));
    send_item(make_item(5678, 8'hF0, 1'b0, 6, 0));
    send_item(make_item(90, 8'h5A, 1'b0, 3, 3));
    send_item(make_item(100, 8'h80, 1'b0, 1, 0));
    send_item(make_item(7, 8'hFF, 1'b0, 0, 1));
    send_item(make_item(5, 8'h00, 1'b1, 5, 1));
    send_item(make_item(40302, 8'h10, 1'b0, 4, 2));
    send_item(make_item(3009, 8'h00, 1'b0, 4, 3));
  endtask

  // font bytes with bit 7 set keep it whatever the dot mask says
  task automatic test_font_bit7();
    write_fonts(40'h80_FF_91_C0_86, 40'hEF_FF_87_FD_ED);
    send_item(make_item(1234, 8'h00, 1'b1, 4, 0));
    send_item(make_item(5678, 8'h00, 1'b0, 4, 1));
    send_item(make_item(9000, 8'h00, 1'b0, 4, 2));
    send_item(make_item(4, 8'h00, 1'b1, 4, 3));
    send_item(make_item(6789, 8'hF0, 1'b0, 4, 0));
    send_item(make_item(12345, 8'h00, 1'b0, 3, 1));
  endtask

  // all-zero and all-one fonts
  task automatic test_font_extremes();
    write_fonts('0, '0);
    repeat (10) send_item(rand_item());
    write_fonts('1, '1);
    repeat (10) send_item(rand_item());
  endtask

  // random fonts, one per phase, the reset font in the last; the first phase runs with no idling at all
  task automatic test_random_items();
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        write_fonts(FONT_LOW_RESET, FONT_HIGH_RESET);
      end else begin
        write_fonts(FONT_W'({$urandom, $urandom}), FONT_W'({$urandom, $urandom}));
      end
      no_idle = (p == 0);
      repeat (PHASE_ITEMS) send_item(rand_item());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_font();
    test_font_bit7();
    test_font_extremes();
    test_random_items();
    wait_idle();
    if (errors == 0 && expected_digits.size() == 0) begin
      $display("tb_decimal_to_seven_segment_formatter OK");
    end else begin
      $display("tb_decimal_to_seven_segment_formatter NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("tb_decimal_to_seven_segment_formatter NOT OK");
    $finish;
  end

endmodule
